// File: sv/tbg_pkg.sv
// Shared types and constants for the tone burst generator.
// No dependencies; compiled first.
package tbg_pkg;

  localparam int TICK_HZ_DEF   = 1000000;
  localparam int MS_PER_SECOND = 1000;
  localparam int FREQ_W        = 16;
  localparam int DUR_W         = 16;
  localparam int CYC_W         = 23;
  localparam int DEN_W         = 16;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TONE = 2'd1,
    MODE_GAP  = 2'd2
  } mode_t;

endpackage

// File: sv/tbg_in_if.sv
// Input channel of the tone burst generator: start requests and ticks.
// Depends on tbg_pkg for field widths.
interface tbg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [tbg_pkg::FREQ_W-1:0]  freq_hz;
  logic [tbg_pkg::DUR_W-1:0]   dur_ms;

  modport source (output valid, output action, output freq_hz, output dur_ms,
                  input ready);
  modport sink   (input valid, input action, input freq_hz, input dur_ms,
                  output ready);
endinterface

// File: sv/tbg_out_if.sv
// Result channel of the tone burst generator: pin level and status flags.
// No dependencies.
interface tbg_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic start_ignored;

  modport source (output valid, output pin_level, output busy_res, output start_ignored,
                  input ready);
  modport sink   (input valid, input pin_level, input busy_res, input start_ignored,
                  output ready);
endinterface

// File: sv/tbg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing; used by tone_burst_generator_core.
module tbg_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (run_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(NUM_W - 1);
      quo_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: sv/tone_burst_generator_core.sv
// Top level of the square-wave tone burst generator.
// Depends on tbg_pkg, tbg_in_if, tbg_out_if and tbg_div.
//
// Items arrive on in_ch: a start request (action 0) with frequency and
// duration, or a one-tick advance (action 1). Every accepted item gives
// exactly one transfer on out_ch with the pin level, the busy flag and a
// flag for a start that was ignored because a burst or a gap was running.
// The sound enable bit is written through cfg_we and cfg_wdata.
// A tick or a start that needs no arithmetic passes from ST_IDLE to
// ST_EMIT, which registers the result; a new item is taken only once
// the state is back in ST_IDLE. A start that runs a burst or a gap
// goes through a bit-serial multiply and one bit-serial divide for a
// gap or two for a burst; both divides use the shared divider.
// One item is worked on at a time.
// Reset clears the burst state and sets sound enable. When out_ch stalls,
// the next input item is still taken, and its result waits until the
// previous one has been transferred.
module tone_burst_generator_core #(
  parameter int TICK_HZ = tbg_pkg::TICK_HZ_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  tbg_in_if.sink    in_ch,
  tbg_out_if.source out_ch,
  input  logic  cfg_we,
  input  logic  cfg_wdata
);
  import tbg_pkg::*;

  localparam int     TICK_W  = $clog2(TICK_HZ + 1);
  localparam int     MCAND_W = (TICK_W > FREQ_W) ? TICK_W : FREQ_W;
  localparam int     PROD_W  = DUR_W + MCAND_W;
  localparam int     HALF_W  = $clog2(TICK_HZ / 2 + 1);
  localparam longint GAP_MAX = (longint'(65535) * longint'(TICK_HZ)) / MS_PER_SECOND;
  localparam int     GAP_W   = $clog2(GAP_MAX + 1);
  localparam int     MCNT_W  = $clog2(DUR_W);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_MUL      = 5'b00010,
    ST_DIV_CYC  = 5'b00100,
    ST_DIV_HALF = 5'b01000,
    ST_EMIT     = 5'b10000
  } state_t;

  state_t              st_r, st_nxt;
  mode_t               mode_r, mode_nxt;
  logic                sound_en_r, sound_en_nxt;
  logic                level_r, level_nxt;
  logic [HALF_W-1:0]   half_r, half_nxt;
  logic [HALF_W-1:0]   phase_r, phase_nxt;
  logic [CYC_W-1:0]    cyc_r, cyc_nxt;
  logic [GAP_W-1:0]    gap_r, gap_nxt;
  logic                ign_r, ign_nxt;
  logic                gap_job_r, gap_job_nxt;
  logic [FREQ_W-1:0]   freq_r, freq_nxt;
  logic [CYC_W-1:0]    cyc_tmp_r, cyc_tmp_nxt;
  logic [MCAND_W-1:0]  mcand_r, mcand_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [MCNT_W-1:0]   mcnt_r, mcnt_nxt;
  logic                ov_r, ov_nxt;
  logic                o_pin_r, o_pin_nxt;
  logic                o_busy_r, o_busy_nxt;
  logic                o_ign_r, o_ign_nxt;

  logic                in_xfer;
  logic                out_free;
  logic [MCAND_W:0]    psum;
  logic [PROD_W-1:0]   prod_step;
  logic                div_start;
  logic [PROD_W-1:0]   div_num;
  logic [DEN_W-1:0]    div_den;
  logic                div_done;
  logic [PROD_W-1:0]   div_quo;
  logic [HALF_W-1:0]   half_new;
  logic [HALF_W-1:0]   phase_dec;
  logic [CYC_W-1:0]    cyc_dec;
  logic [GAP_W-1:0]    gap_dec;

  tbg_div #(.NUM_W(PROD_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && (st_r == ST_IDLE);
  assign out_free    = !ov_r || out_ch.ready;

  assign psum      = {1'b0, prod_r[PROD_W-1:DUR_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
  assign prod_step = {psum, prod_r[DUR_W-1:1]};
  assign half_new  = div_quo[HALF_W:1];
  assign phase_dec = (phase_r != '0) ? phase_r - 1'b1 : phase_r;
  assign cyc_dec   = (cyc_r != '0) ? cyc_r - 1'b1 : cyc_r;
  assign gap_dec   = (gap_r != '0) ? gap_r - 1'b1 : gap_r;

  always_comb begin
    div_start = 1'b0;
    div_num   = prod_step;
    div_den   = DEN_W'(MS_PER_SECOND);
    if (st_r == ST_MUL && mcnt_r == MCNT_W'(DUR_W - 1)) begin
      div_start = 1'b1;
    end else if (st_r == ST_DIV_CYC && div_done && !gap_job_r) begin
      div_start = 1'b1;
      div_num   = PROD_W'(TICK_HZ);
      div_den   = freq_r;
    end
  end

  always_comb begin
    st_nxt       = st_r;
    mode_nxt     = mode_r;
    sound_en_nxt = cfg_we ? cfg_wdata : sound_en_r;
    level_nxt    = level_r;
    half_nxt     = half_r;
    phase_nxt    = phase_r;
    cyc_nxt      = cyc_r;
    gap_nxt      = gap_r;
    ign_nxt      = ign_r;
    gap_job_nxt  = gap_job_r;
    freq_nxt     = freq_r;
    cyc_tmp_nxt  = cyc_tmp_r;
    mcand_nxt    = mcand_r;
    prod_nxt     = prod_r;
    mcnt_nxt     = mcnt_r;
    ov_nxt       = out_free ? 1'b0 : ov_r;
    o_pin_nxt    = o_pin_r;
    o_busy_nxt   = o_busy_r;
    o_ign_nxt    = o_ign_r;

    case (st_r)
      ST_IDLE: begin
        if (in_xfer) begin
          st_nxt  = ST_EMIT;
          ign_nxt = 1'b0;
          if (!in_ch.action) begin
            if (sound_en_r) begin
              if (mode_r != MODE_IDLE) begin
                ign_nxt = 1'b1;
              end else if (in_ch.freq_hz != '0 || in_ch.dur_ms != '0) begin
                st_nxt      = ST_MUL;
                gap_job_nxt = (in_ch.freq_hz == '0);
                freq_nxt    = in_ch.freq_hz;
                mcand_nxt   = (in_ch.freq_hz == '0) ? MCAND_W'(TICK_HZ)
                                                    : MCAND_W'(in_ch.freq_hz);
                prod_nxt    = {{MCAND_W{1'b0}}, in_ch.dur_ms};
                mcnt_nxt    = '0;
              end
            end
          end else begin
            case (mode_r)
              MODE_GAP: begin
                gap_nxt = gap_dec;
                if (gap_dec == '0) begin
                  mode_nxt  = MODE_IDLE;
                  level_nxt = 1'b0;
                  phase_nxt = '0;
                  cyc_nxt   = '0;
                end
              end
              MODE_TONE: begin
                phase_nxt = phase_dec;
                if (phase_dec == '0) begin
                  if (level_r) begin
                    level_nxt = 1'b0;
                    phase_nxt = half_r;
                  end else if (cyc_dec == '0) begin
                    mode_nxt  = MODE_IDLE;
                    level_nxt = 1'b0;
                    phase_nxt = '0;
                    cyc_nxt   = '0;
                    gap_nxt   = '0;
                  end else begin
                    cyc_nxt   = cyc_dec;
                    level_nxt = 1'b1;
                    phase_nxt = half_r;
                  end
                end
              end
              default: begin
                mode_nxt = mode_r;
              end
            endcase
          end
        end
      end
      ST_MUL: begin
        prod_nxt = prod_step;
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == MCNT_W'(DUR_W - 1)) begin
          st_nxt = ST_DIV_CYC;
        end
      end
      ST_DIV_CYC: begin
        if (div_done) begin
          if (gap_job_r) begin
            st_nxt    = ST_EMIT;
            gap_nxt   = div_quo[GAP_W-1:0];
            level_nxt = 1'b0;
            mode_nxt  = MODE_GAP;
          end else begin
            st_nxt      = ST_DIV_HALF;
            cyc_tmp_nxt = div_quo[CYC_W-1:0];
          end
        end
      end
      ST_DIV_HALF: begin
        if (div_done) begin
          st_nxt = ST_EMIT;
          if (half_new != '0 && cyc_tmp_r != '0) begin
            half_nxt  = half_new;
            phase_nxt = half_new;
            cyc_nxt   = cyc_tmp_r;
            level_nxt = 1'b1;
            mode_nxt  = MODE_TONE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          st_nxt     = ST_IDLE;
          ov_nxt     = 1'b1;
          o_pin_nxt  = level_r;
          o_busy_nxt = (mode_r == MODE_TONE) || (mode_r == MODE_GAP);
          o_ign_nxt  = ign_r;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      mode_r     <= MODE_IDLE;
      sound_en_r <= 1'b1;
      level_r    <= 1'b0;
      half_r     <= '0;
      phase_r    <= '0;
      cyc_r      <= '0;
      gap_r      <= '0;
      ov_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      mode_r     <= mode_nxt;
      sound_en_r <= sound_en_nxt;
      level_r    <= level_nxt;
      half_r     <= half_nxt;
      phase_r    <= phase_nxt;
      cyc_r      <= cyc_nxt;
      gap_r      <= gap_nxt;
      ov_r       <= ov_nxt;
    end
    ign_r     <= ign_nxt;
    gap_job_r <= gap_job_nxt;
    freq_r    <= freq_nxt;
    cyc_tmp_r <= cyc_tmp_nxt;
    mcand_r   <= mcand_nxt;
    prod_r    <= prod_nxt;
    mcnt_r    <= mcnt_nxt;
    o_pin_r   <= o_pin_nxt;
    o_busy_r  <= o_busy_nxt;
    o_ign_r   <= o_ign_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.pin_level     = o_pin_r;
  assign out_ch.busy_res      = o_busy_r;
  assign out_ch.start_ignored = o_ign_r;

endmodule
